FILE: design/pfsa_pkg.sv
// ---------------------------------------------------------------------------
// Page frame stack allocator package
// Sizes, operation and status codes, controller states and the result beat
// type shared by the allocator, its output register and its checker.
// ---------------------------------------------------------------------------
package pfsa_pkg;

	localparam int DEPTH      = 131072;
	localparam int IDX_W      = $clog2(DEPTH);
	localparam int CNT_W      = $clog2(DEPTH + 1);
	localparam int PAGE_SHIFT = 12;
	localparam int PN_W       = 17;
	localparam int ADDR_W     = 32;
	localparam int LEN_W      = 32;
	localparam int PA_W       = PN_W + PAGE_SHIFT;
	localparam int FREE_W     = 18;
	localparam int FUNC_W     = 2;
	localparam int STAT_W     = 2;

	localparam logic [ADDR_W-1:0] LOW_LIMIT  = 32'h0010_0000;
	localparam logic [ADDR_W-1:0] HIGH_LIMIT = 32'h2000_0000;

	typedef enum logic [FUNC_W-1:0] {
		FUNC_FREE    = 2'd0,
		FUNC_ALLOC   = 2'd1,
		FUNC_RESERVE = 2'd2,
		FUNC_CLEAR   = 2'd3
	} func_t;

	typedef enum logic [STAT_W-1:0] {
		STAT_OK       = 2'd0,
		STAT_EMPTY    = 2'd1,
		STAT_BAD_ADDR = 2'd2,
		STAT_FULL     = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RSV_ISSUE,
		ST_RSV_CHK,
		ST_RSV_MOVE,
		ST_RSV_RECHK,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic [PA_W-1:0]   page_address;
		logic [STAT_W-1:0] status;
		logic [FREE_W-1:0] free_pages;
	} rsp_t;

endpackage

FILE: design/pfsa_req_if.sv
// ---------------------------------------------------------------------------
// Allocator request channel
// Valid/ready channel carrying one operation per beat.
// ---------------------------------------------------------------------------
interface pfsa_req_if;
	logic                          valid;
	logic                          ready;
	logic [pfsa_pkg::FUNC_W-1:0]   func;
	logic [pfsa_pkg::ADDR_W-1:0]   address;
	logic [pfsa_pkg::LEN_W-1:0]    length;

	modport source (output valid, output func, output address, output length, input ready);
	modport sink   (input valid, input func, input address, input length, output ready);
endinterface

FILE: design/pfsa_rsp_if.sv
// ---------------------------------------------------------------------------
// Allocator response channel
// Valid/ready channel carrying one result per beat.
// ---------------------------------------------------------------------------
interface pfsa_rsp_if;
	logic                          valid;
	logic                          ready;
	logic [pfsa_pkg::PA_W-1:0]     page_address;
	logic [pfsa_pkg::STAT_W-1:0]   status;
	logic [pfsa_pkg::FREE_W-1:0]   free_pages;

	modport source (output valid, output page_address, output status, output free_pages,
		input ready);
	modport sink   (input valid, input page_address, input status, input free_pages,
		output ready);
endinterface

FILE: design/pfsa_out_reg.sv
// ---------------------------------------------------------------------------
// Allocator output register
// Holds one finished result beat until the receiver takes it.
// ---------------------------------------------------------------------------
module pfsa_out_reg (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               load,
	input  pfsa_pkg::rsp_t     data,
	output logic               free,
	pfsa_rsp_if.source         rsp
);
	import pfsa_pkg::*;

	logic valid_q;
	rsp_t data_q;

	assign free = !valid_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (rsp.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= data;
		end
	end

	assign rsp.valid        = valid_q;
	assign rsp.page_address = data_q.page_address;
	assign rsp.status       = data_q.status;
	assign rsp.free_pages   = data_q.free_pages;

endmodule

FILE: design/page_frame_stack_allocator_top.sv
// ---------------------------------------------------------------------------
// Page frame stack allocator
// Free list of 4 KiB physical pages in [1 MiB, 512 MiB) kept as a stack.
// ---------------------------------------------------------------------------
// Usage:
//   req carries one operation per beat: free (push a page), allocate (pop
//   the top page), reserve (remove every held page inside a byte range) and
//   clear. rsp returns exactly one beat per request with the popped address,
//   a status code and the number of pages held afterwards.
//   The stack lives in a single memory with a registered read; one request
//   is worked at a time. Free, allocate and clear go from the request beat
//   to a finish state that loads their result into the output register once
//   it is free; the controller then returns to idle for the next request.
//   Reserve walks the whole stack one entry at a time through the single
//   read port of the memory, replacing each removed entry with the top one.
//   The next request is taken as soon as the previous result has been
//   loaded into the output register, even if the receiver has not taken it.
//   If the receiver stalls, one further request is worked and then waits.
//   Reset empties the stack (count to zero); memory contents are not
//   cleared since an entry is only read after it has been written.
// ---------------------------------------------------------------------------
module page_frame_stack_allocator_top (
	input  logic        clk,
	input  logic        arst_n,
	pfsa_req_if.sink    req,
	pfsa_rsp_if.source  rsp
);
	import pfsa_pkg::*;

	state_t              state_q, state_d;
	logic [CNT_W-1:0]    cnt_q, idx_q, cnt_m1;
	logic [ADDR_W-1:0]   start_q;
	logic [ADDR_W:0]     end_q;
	logic [PN_W-1:0]     held_q, rd_data_q, cur_pn;
	logic [ADDR_W:0]     cur_pa;
	status_t             res_status_q, res_status_d;
	logic                res_alloc_q, res_alloc_d;
	logic                fire, idx_live, in_rng, bad_addr, full, empty, out_free;
	func_t               func;

	// Controls from the output decoder
	logic                mem_we, mem_re;
	logic [IDX_W-1:0]    mem_waddr, mem_raddr;
	logic [PN_W-1:0]     mem_wdata;
	logic                cnt_inc, cnt_dec, cnt_clr, idx_inc, idx_clr;
	logic                held_load, res_load, rng_load, out_load;

	logic [PN_W-1:0]     mem [DEPTH];
	rsp_t                out_data;

	assign func      = func_t'(req.func);
	assign req.ready = (state_q == ST_IDLE);
	assign fire      = req.valid && req.ready;

	assign bad_addr = (req.address[PAGE_SHIFT-1:0] != '0) || (req.address < LOW_LIMIT)
		|| (req.address >= HIGH_LIMIT);
	assign full     = (cnt_q >= CNT_W'(DEPTH));
	assign empty    = (cnt_q == '0) || (cnt_q > CNT_W'(DEPTH));
	assign cnt_m1   = cnt_q - CNT_W'(1);
	assign idx_live = (idx_q < cnt_q);

	// After a removal the replacement value is held in a register and checked again.
	assign cur_pn = (state_q == ST_RSV_RECHK) ? held_q : rd_data_q;
	assign cur_pa = (ADDR_W+1)'({cur_pn, {PAGE_SHIFT{1'b0}}});
	assign in_rng = (cur_pa >= {1'b0, start_q}) && (cur_pa < end_q);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (fire) begin
					state_d = (func == FUNC_RESERVE) ? ST_RSV_ISSUE : ST_FIN;
				end
			end
			ST_RSV_ISSUE: begin
				state_d = idx_live ? ST_RSV_CHK : ST_FIN;
			end
			ST_RSV_CHK, ST_RSV_RECHK: begin
				priority if (!idx_live) begin
					state_d = ST_FIN;
				end else if (in_rng) begin
					state_d = ST_RSV_MOVE;
				end else begin
					state_d = ST_RSV_ISSUE;
				end
			end
			ST_RSV_MOVE: begin
				state_d = ST_RSV_RECHK;
			end
			ST_FIN: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		mem_we       = 1'b0;
		mem_re       = 1'b0;
		mem_waddr    = idx_q[IDX_W-1:0];
		mem_raddr    = idx_q[IDX_W-1:0];
		mem_wdata    = rd_data_q;
		cnt_inc      = 1'b0;
		cnt_dec      = 1'b0;
		cnt_clr      = 1'b0;
		idx_inc      = 1'b0;
		idx_clr      = 1'b0;
		held_load    = 1'b0;
		res_load     = 1'b0;
		rng_load     = 1'b0;
		out_load     = 1'b0;
		res_status_d = STAT_OK;
		res_alloc_d  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (fire) begin
					res_load = 1'b1;
					unique case (func)
						FUNC_FREE: begin
							priority if (bad_addr) begin
								res_status_d = STAT_BAD_ADDR;
							end else if (full) begin
								res_status_d = STAT_FULL;
							end else begin
								mem_we    = 1'b1;
								mem_waddr = cnt_q[IDX_W-1:0];
								mem_wdata = req.address[PAGE_SHIFT +: PN_W];
								cnt_inc   = 1'b1;
							end
						end
						FUNC_ALLOC: begin
							if (empty) begin
								res_status_d = STAT_EMPTY;
							end else begin
								mem_re      = 1'b1;
								mem_raddr   = cnt_m1[IDX_W-1:0];
								cnt_dec     = 1'b1;
								res_alloc_d = 1'b1;
							end
						end
						FUNC_RESERVE: begin
							idx_clr  = 1'b1;
							rng_load = 1'b1;
						end
						FUNC_CLEAR: begin
							cnt_clr = 1'b1;
						end
						default: begin
							res_status_d = STAT_OK;
						end
					endcase
				end
			end
			ST_RSV_ISSUE: begin
				mem_re = idx_live;
			end
			ST_RSV_CHK, ST_RSV_RECHK: begin
				if (idx_live) begin
					if (in_rng) begin
						cnt_dec   = 1'b1;
						mem_re    = 1'b1;
						mem_raddr = cnt_m1[IDX_W-1:0];
					end else begin
						idx_inc = 1'b1;
					end
				end
			end
			ST_RSV_MOVE: begin
				mem_we    = 1'b1;
				held_load = 1'b1;
			end
			ST_FIN: begin
				out_load = out_free;
			end
			default: begin
				out_load = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			idx_q   <= '0;
		end else begin
			state_q <= state_d;
			priority if (cnt_clr) begin
				cnt_q <= '0;
			end else if (cnt_inc) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (cnt_dec) begin
				cnt_q <= cnt_m1;
			end
			priority if (idx_clr) begin
				idx_q <= '0;
			end else if (idx_inc) begin
				idx_q <= idx_q + CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rng_load) begin
			start_q <= req.address;
			end_q   <= {1'b0, req.address} + {1'b0, req.length};
		end
		if (res_load) begin
			res_status_q <= res_status_d;
			res_alloc_q  <= res_alloc_d;
		end
		if (held_load) begin
			held_q <= rd_data_q;
		end
	end

	// Stack memory: one write port and one registered read port.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rd_data_q <= mem[mem_raddr];
		end
	end

	assign out_data.page_address = res_alloc_q ? {rd_data_q, {PAGE_SHIFT{1'b0}}} : '0;
	assign out_data.status       = res_status_q;
	assign out_data.free_pages   = cnt_q[FREE_W-1:0];

	pfsa_out_reg u_out_reg (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (out_load),
		.data   (out_data),
		.free   (out_free),
		.rsp    (rsp)
	);

endmodule

FILE: design/pfsa_checker.sv
// ---------------------------------------------------------------------------
// Allocator port checker
// Watches the request and response ports of the allocator top level.
// ---------------------------------------------------------------------------
module pfsa_port_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          req_valid,
	input logic                          req_ready,
	input logic                          rsp_valid,
	input logic                          rsp_ready,
	input logic [pfsa_pkg::PA_W-1:0]     page_address,
	input logic [pfsa_pkg::STAT_W-1:0]   status,
	input logic [pfsa_pkg::FREE_W-1:0]   free_pages
);
	import pfsa_pkg::*;

	// A held result beat must not change until it is taken.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(page_address)
			&& $stable(status) && $stable(free_pages))
		else $error("response beat changed while stalled");

	// Requests are worked one at a time.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken while previous one in progress");

	// Only a successful allocation returns an address.
	a_addr_only_ok: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (status != STAT_OK) |-> page_address == '0)
		else $error("address returned with a failing status");

	// Returned pages are aligned and inside the managed window.
	a_addr_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (page_address != '0) |->
			(page_address[PAGE_SHIFT-1:0] == '0)
			&& ({{(ADDR_W-PA_W){1'b0}}, page_address} >= LOW_LIMIT))
		else $error("returned page outside the managed window");

endmodule

bind page_frame_stack_allocator_top pfsa_port_checker u_pfsa_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.req_valid    (req.valid),
	.req_ready    (req.ready),
	.rsp_valid    (rsp.valid),
	.rsp_ready    (rsp.ready),
	.page_address (rsp.page_address),
	.status       (rsp.status),
	.free_pages   (rsp.free_pages)
);
